>>> hw/rtl/pci_id_extract_and_lookup_core_defines.svh
// Assertion macros for the PCI id scanner.
// Standalone header; included by the modules that assert.
`ifndef PCI_ID_EXTRACT_AND_LOOKUP_CORE_DEFINES_SVH
`define PCI_ID_EXTRACT_AND_LOOKUP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PIDL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define PIDL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PIDL_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define PIDL_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

>>> hw/rtl/pidl_pkg.sv
// Package for the PCI id scanner: field widths, table reset values and
// the hex digit decoder. No dependencies.
package pidl_pkg;

  localparam int TABLE_MAX   = 4;
  localparam int ENTRY_W     = 32;
  localparam int ID_W        = 16;
  localparam int IDX_W       = 2;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 40;
  localparam int TUSER_OUT_W = 2;

  localparam logic [7:0] COLON_CHAR = 8'h3A;
  localparam logic [2:0] DEV_DIGITS_MAX = 3'd4;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef entry_t entry_tab_t [TABLE_MAX];

  localparam entry_tab_t ENTRY_RESET = '{
    32'h8086_100E, 32'h8086_10D3, 32'h1AF4_1000, 32'h1AF4_1001
  };

  // bit 4 set: not a hex digit; otherwise bits 3..0 hold the value
  typedef struct packed {
    logic       non_hex;
    logic [3:0] value;
  } digit_t;

  function automatic digit_t hex_digit(input logic [7:0] b);
    digit_t d;
    d = '{non_hex: 1'b0, value: 4'd0};
    if (b >= 8'h30 && b <= 8'h39) begin
      d.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d.value = 4'(b - 8'h37);
    end else begin
      d.non_hex = 1'b1;
    end
    return d;
  endfunction

endpackage

>>> hw/rtl/pci_id_extract_and_lookup_core.sv
// PCI id scanner top level: byte-wise vendor:device parser, table compare
// and result register. Depends on pidl_pkg and the defines header.
//
//   channel   | dir | payload
//   ----------+-----+--------------------------------------------------
//   s_axis    | in  | tdata: text byte; tlast: last byte of the query
//   m_axis    | out | tdata: vendor, device, entry index; tuser: flags
//   cfg       | in  | write of one of the table entries
//
// One byte is taken every cycle unless s_axis stalls; a query's result is
// registered in the cycle after its last byte. The scan step and the four
// entry compares sit between the scan state and result registers.
// Reset (synchronous) clears the scan state, empties the result register
// and restores the table. s_axis stalls only while a result waits unread.
`include "pci_id_extract_and_lookup_core_defines.svh"

module pci_id_extract_and_lookup_core
  import pidl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic                   s_axis_tlast,   // last_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [15:0] vendor_id, [31:16] device_id,
                                                 // [33:32] entry_index, [39:34] zero
  output logic [TUSER_OUT_W-1:0] m_axis_tuser,   // [0] id_found, [1] table_hit
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [ENTRY_W-1:0]     cfg_data
);

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_COLON  = 2'd1,
    PH_DEVICE = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  entry_t entries [TABLE_ENTRIES];

  phase_t     scan_phase, scan_phase_next;
  logic [15:0] hex_run, hex_run_next;
  logic        run_nonempty, run_nonempty_next;
  logic [15:0] held_vendor, held_vendor_next;
  logic [15:0] device_accum, device_accum_next;
  logic [2:0]  device_digits, device_digits_next;

  logic       accept;
  digit_t     dig;
  logic       found;
  logic       hit;
  logic [IDX_W-1:0] hit_idx;
  entry_t     key;

  logic             out_found;
  logic             out_hit;
  logic [ID_W-1:0]  out_vendor;
  logic [ID_W-1:0]  out_device;
  logic [IDX_W-1:0] out_idx;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign dig           = hex_digit(s_axis_tdata);

  // Scan step for the byte on the input.
  always_comb begin
    scan_phase_next    = scan_phase;
    hex_run_next       = hex_run;
    run_nonempty_next  = run_nonempty;
    held_vendor_next   = held_vendor;
    device_accum_next  = device_accum;
    device_digits_next = device_digits;
    case (scan_phase)
      PH_SEARCH: begin
        if (!dig.non_hex) begin
          hex_run_next      = {hex_run[11:0], dig.value};
          run_nonempty_next = 1'b1;
        end else begin
          if (s_axis_tdata == COLON_CHAR && run_nonempty) begin
            held_vendor_next = hex_run;
            scan_phase_next  = PH_COLON;
          end
          hex_run_next      = '0;
          run_nonempty_next = 1'b0;
        end
      end
      PH_COLON: begin
        if (!dig.non_hex) begin
          device_accum_next  = {12'd0, dig.value};
          device_digits_next = 3'd1;
          scan_phase_next    = PH_DEVICE;
        end else begin
          // colon with no digit after it: drop and search again
          held_vendor_next = '0;
          scan_phase_next  = PH_SEARCH;
        end
      end
      PH_DEVICE: begin
        if (!dig.non_hex && device_digits < DEV_DIGITS_MAX) begin
          device_accum_next  = {device_accum[11:0], dig.value};
          device_digits_next = device_digits + 3'd1;
        end else begin
          scan_phase_next = PH_DONE;
        end
      end
      default: ;
    endcase
  end

  // Lookup against the table, lowest entry wins.
  always_comb begin
    found   = (scan_phase_next == PH_DEVICE) || (scan_phase_next == PH_DONE);
    key     = {held_vendor_next, device_accum_next};
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (found && entries[i] == key) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        entries[i] <= ENTRY_RESET[i];
      end
    end else if (cfg_we) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (int'(cfg_index) == i) begin
          entries[i] <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase    <= PH_SEARCH;
      hex_run       <= '0;
      run_nonempty  <= 1'b0;
      held_vendor   <= '0;
      device_accum  <= '0;
      device_digits <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        // clear for the next query
        scan_phase    <= PH_SEARCH;
        hex_run       <= '0;
        run_nonempty  <= 1'b0;
        held_vendor   <= '0;
        device_accum  <= '0;
        device_digits <= '0;
      end else begin
        scan_phase    <= scan_phase_next;
        hex_run       <= hex_run_next;
        run_nonempty  <= run_nonempty_next;
        held_vendor   <= held_vendor_next;
        device_accum  <= device_accum_next;
        device_digits <= device_digits_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept && s_axis_tlast) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_axis_tlast) begin
      out_found  <= found;
      out_hit    <= hit;
      out_vendor <= found ? held_vendor_next : '0;
      out_device <= found ? device_accum_next : '0;
      out_idx    <= hit_idx;
    end
  end

  assign m_axis_tdata = {6'd0, out_idx, out_device, out_vendor};
  assign m_axis_tuser = {out_hit, out_found};

  `PIDL_ASSERT_NXT(a_last_gives_result, clk, rst, accept && s_axis_tlast,
                   m_axis_tvalid, "last byte accepted but no result")
  `PIDL_ASSERT_NXT(a_scan_cleared, clk, rst, accept && s_axis_tlast,
                   scan_phase == PH_SEARCH && !run_nonempty && device_digits == 3'd0,
                   "scan state not cleared after query")
  `PIDL_ASSERT_IMP(a_hit_needs_id, clk, rst, m_axis_tvalid && m_axis_tuser[1],
                   m_axis_tuser[0], "table hit without an id")
  `PIDL_ASSERT_IMP(a_empty_result_zero, clk, rst, m_axis_tvalid && !m_axis_tuser[0],
                   m_axis_tdata == '0 && !m_axis_tuser[1], "no id but fields not zero")

endmodule

>>> tb/pci_id_extract_and_lookup_core_checker.sv
// Checker for the PCI id scanner: watches the byte, result and table write
// ports, tracks the scan and the table itself and compares every result.
// Depends on pidl_pkg.
`timescale 1ns / 100ps

module pci_id_extract_and_lookup_core_checker
  import pidl_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [TDATA_OUT_W-1:0] m_axis_tdata,
  input  logic [TUSER_OUT_W-1:0] m_axis_tuser,
  input  logic                   cfg_we,
  input  logic [IDX_W-1:0]       cfg_index,
  input  logic [ENTRY_W-1:0]     cfg_data,
  output int                     fail_count,
  output int                     pending
);

  typedef enum logic [1:0] {
    SCAN_SEARCH,
    SCAN_COLON,
    SCAN_DEVICE,
    SCAN_DONE
  } scan_phase_t;

  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] vendor;
    logic [ID_W-1:0] device;
    logic            hit;
    logic [IDX_W-1:0] index;
  } id_report_t;

  entry_tab_t    table_copy;
  scan_phase_t   phase;
  logic [15:0]   run_digits;
  logic          run_seen;
  logic [15:0]   vendor_held;
  logic [15:0]   device_sum;
  logic [2:0]    device_count;
  id_report_t    ids_due [$];
  id_report_t    got_id;
  id_report_t    want_id;
  int            results_seen = 0;

  initial begin
    fail_count = 0;
  end

  // {non-hex flag, value}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h61 + 8'd10)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h41 + 8'd10)};
    return 5'h10;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] result %0d: %s got %h, expected %h", $realtime, results_seen,
             what, got, want);
    fail_count++;
  endtask

  task automatic clear_scan();
    phase        = SCAN_SEARCH;
    run_digits   = '0;
    run_seen     = 1'b0;
    vendor_held  = '0;
    device_sum   = '0;
    device_count = '0;
  endtask

  task automatic scan_text_byte(input logic [7:0] c, input logic last);
    logic [4:0]  nib;
    id_report_t  res;
    logic [31:0] key;
    nib = nibble_of(c);
    case (phase)
      SCAN_SEARCH: begin
        if (!nib[4]) begin
          run_digits = {run_digits[11:0], nib[3:0]};
          run_seen   = 1'b1;
        end else begin
          if (c == COLON_CHAR && run_seen) begin
            vendor_held = run_digits;
            phase       = SCAN_COLON;
          end
          run_digits = '0;
          run_seen   = 1'b0;
        end
      end
      SCAN_COLON: begin
        if (!nib[4]) begin
          device_sum   = {12'h000, nib[3:0]};
          device_count = 3'd1;
          phase        = SCAN_DEVICE;
        end else begin
          // drop the colon and resume searching
          vendor_held = '0;
          phase       = SCAN_SEARCH;
        end
      end
      SCAN_DEVICE: begin
        if (!nib[4] && device_count < DEV_DIGITS_MAX) begin
          device_sum   = {device_sum[11:0], nib[3:0]};
          device_count = device_count + 3'd1;
        end else begin
          phase = SCAN_DONE;
        end
      end
      default: ;
    endcase
    if (last) begin
      res       = '0;
      res.found = (phase == SCAN_DEVICE || phase == SCAN_DONE);
      if (res.found) begin
        res.vendor = vendor_held;
        res.device = device_sum;
        key = {vendor_held, device_sum};
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
          if (table_copy[i] == key) begin
            res.hit   = 1'b1;
            res.index = IDX_W'(i);
          end
        end
      end
      ids_due.push_back(res);
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      table_copy = ENTRY_RESET;
      clear_scan();
      ids_due.delete();
    end else begin
      if (cfg_we) table_copy[cfg_index] = cfg_data;
      if (s_axis_tvalid && s_axis_tready) scan_text_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got_id.found  = m_axis_tuser[0];
        got_id.hit    = m_axis_tuser[1];
        got_id.vendor = m_axis_tdata[15:0];
        got_id.device = m_axis_tdata[31:16];
        got_id.index  = m_axis_tdata[33:32];
        if (ids_due.size() == 0) begin
          report_mismatch("unrequested result, tdata low", m_axis_tdata[15:0], '0);
        end else begin
          want_id = ids_due.pop_front();
          if (got_id.found !== want_id.found)
            report_mismatch("id_found", 16'(got_id.found), 16'(want_id.found));
          if (got_id.vendor !== want_id.vendor)
            report_mismatch("vendor_id", got_id.vendor, want_id.vendor);
          if (got_id.device !== want_id.device)
            report_mismatch("device_id", got_id.device, want_id.device);
          if (got_id.hit !== want_id.hit)
            report_mismatch("table_hit", 16'(got_id.hit), 16'(want_id.hit));
          if (got_id.index !== want_id.index)
            report_mismatch("entry_index", 16'(got_id.index), 16'(want_id.index));
          if (m_axis_tdata[39:34] !== 6'd0)
            report_mismatch("tdata padding", 16'(m_axis_tdata[39:34]), '0);
        end
      end
    end
    pending <= ids_due.size();
  end

endmodule

>>> tb/pci_id_extract_and_lookup_core_test.sv
// Top of the PCI id scanner testbench: clock, reset, query and table
// stimulus, result back-pressure and the verdict.
// Depends on pidl_pkg, the block and pci_id_extract_and_lookup_core_checker.
`timescale 1ns / 100ps

module pci_id_extract_and_lookup_core_test;
  import pidl_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int BYTES_PER_PHASE = 170;
  localparam int PHASES          = 5;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic [TUSER_OUT_W-1:0] m_axis_tuser;
  logic                   cfg_we        = 1'b0;
  logic [IDX_W-1:0]       cfg_index     = '0;
  logic [ENTRY_W-1:0]     cfg_data      = '0;

  int          fail_count;
  int          pending;
  logic        idle_on     = 1'b1;
  int          stall_left  = 0;
  int          cycle_count = 0;
  int          bytes_sent  = 0;
  entry_t      entry_now [TABLE_MAX];
  logic [7:0]  query_bytes [$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pci_id_extract_and_lookup_core #(.TABLE_ENTRIES(4)) u_dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we, .cfg_index, .cfg_data
  );

  pci_id_extract_and_lookup_core_checker #(.TABLE_ENTRIES(4)) u_checker (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending
  );

  // random bursts of result back-pressure, started only while idle_on is set
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left    <= $urandom_range(1, 13) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** pci_id_extract_and_lookup_core: FAILED **");
      $finish;
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    return c;
  endfunction

  task automatic push_hex(input logic [15:0] v, input int ndig);
    for (int i = ndig - 1; i >= 0; i--) query_bytes.push_back(hex_char(v[4*i +: 4]));
  endtask

  task automatic push_text(input string t);
    for (int i = 0; i < t.len(); i++) query_bytes.push_back(t[i]);
  endtask

  task automatic build_query();
    int kind;
    int e;
    query_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      // well-formed id with noise around it
      repeat ($urandom_range(0, 3))
        query_bytes.push_back($urandom_range(0, 3) == 0 ? COLON_CHAR : non_hex_char());
      repeat ($urandom_range(0, 3)) query_bytes.push_back(hex_char(4'($urandom)));
      if ($urandom_range(0, 1)) begin
        e = $urandom_range(0, TABLE_MAX - 1);
        push_hex(entry_now[e][31:16], 4);
        query_bytes.push_back(COLON_CHAR);
        push_hex(entry_now[e][15:0], 4);
      end else begin
        push_hex(16'($urandom), $urandom_range(1, 4));
        query_bytes.push_back(COLON_CHAR);
        push_hex(16'($urandom), $urandom_range(1, 4));
        repeat ($urandom_range(0, 2)) query_bytes.push_back(hex_char(4'($urandom)));
      end
      repeat ($urandom_range(0, 4)) query_bytes.push_back(8'($urandom));
    end else if (kind <= 7) begin
      // broken fragments: stray colons, short runs, junk
      repeat ($urandom_range(3, 8)) begin
        case ($urandom_range(0, 3))
          0: query_bytes.push_back(COLON_CHAR);
          1: push_hex(16'($urandom), $urandom_range(1, 4));
          2: query_bytes.push_back(non_hex_char());
          default: query_bytes.push_back(8'($urandom));
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 12))
        query_bytes.push_back($urandom_range(0, 3) == 0 ? COLON_CHAR : 8'($urandom));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_query();
    for (int i = 0; i < query_bytes.size(); i++)
      send_byte(query_bytes[i], i == query_bytes.size() - 1);
    query_bytes.delete();
  endtask

  // hold the sender until every result is back, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_table(input entry_t v0, input entry_t v1, input entry_t v2,
                            input entry_t v3);
    entry_t vals [TABLE_MAX];
    vals = '{v0, v1, v2, v3};
    for (int i = 0; i < TABLE_MAX; i++) begin
      cfg_we       <= 1'b1;
      cfg_index    <= IDX_W'(i);
      cfg_data     <= vals[i];
      entry_now[i] = vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    entry_t ra;
    entry_t rb;
    entry_t rc;
    entry_now = ENTRY_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    query_bytes.push_back(8'h00);
    send_query();
    query_bytes.push_back(8'hFF);
    send_query();
    push_text(":");          // colon with no digit before it
    send_query();
    push_text("a:g");        // colon with no digit after it
    send_query();
    push_text("8086:100e");
    send_query();
    push_text("9:");         // query ends right after the colon
    send_query();
    push_text("F:12345");    // fifth device digit closes the id
    send_query();

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) drain();
      case (phase)
        1: load_table(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: load_table(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        3: begin
          ra = $urandom;
          rb = $urandom;
          rc = $urandom;
          load_table(ra, rb, rc, rb);
        end
        4: begin
          idle_on = 1'b0;
          load_table($urandom, $urandom, $urandom, $urandom);
        end
        default: ;
      endcase
      while (bytes_sent < (phase + 1) * BYTES_PER_PHASE) begin
        build_query();
        send_query();
      end
    end
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("** pci_id_extract_and_lookup_core: PASSED **");
    end else begin
      $display("** pci_id_extract_and_lookup_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> pci_id_extract_and_lookup_core.f
+incdir+hw/rtl
hw/rtl/pidl_pkg.sv
hw/rtl/pci_id_extract_and_lookup_core.sv
tb/pci_id_extract_and_lookup_core_checker.sv
tb/pci_id_extract_and_lookup_core_test.sv
